>>> src/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// text_console_writer_macros.svh
// Assertion macros used by the console writer checker tcw_checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// check a property on the rising clock, skipped while reset is high
`define TCW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property on the rising clock, also across reset
`define TCW_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and helpers of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int WIDTH_DEF  = 80;
   localparam int HEIGHT_DEF = 25;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [0:0] REG_FG = 1'b0;
   localparam logic [0:0] REG_BG = 1'b1;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam logic [15:0] CELL_RESET = 16'h0020;

   localparam logic [3:0] FG_RESET = 4'd15;
   localparam logic [3:0] BG_RESET = 4'd0;

   typedef logic [15:0] cell_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  char_code;
      logic [3:0]  clear_bg;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [15:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic cursor_load;
      logic cell_write;
      logic sweep_start;
      logic sweep_clear;
      logic read_issue;
      logic rsp_load_step;
      logic rsp_load_read;
   } cmd_type;

   typedef struct packed {
      logic will_scroll;
      logic is_newline;
      logic sweep_busy;
   } status_type;

   function automatic cell_type make_cell(logic [3:0] bg, logic [3:0] fg, logic [7:0] ch);
      return {bg, fg, ch};
   endfunction

endpackage

>>> src/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: input and result handshakes, command sequencing.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tcw_pkg::status_type status,
   output tcw_pkg::cmd_type    cmd
);
   import tcw_pkg::*;

   localparam logic [1:0] S_SWEEP = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_SWEEP: begin
            if (!status.sweep_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_PUT: begin
                     cmd.cursor_load   = 1'b1;
                     cmd.cell_write    = !status.is_newline;
                     cmd.rsp_load_step = 1'b1;
                     rsp_valid_in      = 1'b1;
                     if (status.will_scroll) begin
                        cmd.sweep_start = 1'b1;
                        state_in        = S_SWEEP;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.cursor_load   = 1'b1;
                     cmd.sweep_start   = 1'b1;
                     cmd.sweep_clear   = 1'b1;
                     cmd.rsp_load_step = 1'b1;
                     rsp_valid_in      = 1'b1;
                     state_in          = S_SWEEP;
                  end
                  OP_READ: begin
                     cmd.read_issue = 1'b1;
                     state_in       = S_READ;
                  end
                  default: begin
                     cmd.rsp_load_step = 1'b1;
                     rsp_valid_in      = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load_read = 1'b1;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath: cursor, color registers, screen store, sweep engine, result beat.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
   parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::req_type    req_data,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [3:0]          csr_wdata,
   input  tcw_pkg::cmd_type    cmd,
   output tcw_pkg::status_type status,
   output tcw_pkg::rsp_type    rsp_data
);
   import tcw_pkg::*;

   localparam int CELLS = WIDTH * HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(WIDTH);
   localparam int RW    = $clog2(HEIGHT);

   logic [3:0]    fg_ff, bg_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW:0]   col_inc;
   logic          eol, last_row, line_next, newline;

   logic          sweep_on_ff;
   logic [AW-1:0] sweep_cnt_ff;
   logic          sweep_copy_ff;
   cell_type      fill_ff;
   logic          wr_pend_ff;
   logic [AW-1:0] wr_addr_ff;
   logic          wr_copy_ff;
   logic          in_range_ff;
   rsp_type       rsp_ff;

   logic [AW-1:0] pos_cur, pos_next, idx_addr;
   logic [31:0]   idx_wide;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   cell_type      ram_wdata, ram_q;

   function automatic logic [10:0] to_pos(logic [AW-1:0] p);
      logic [31:0] wide;
      wide = 32'(p);
      return wide[10:0];
   endfunction

   assign newline  = req_data.char_code == CH_NEWLINE;
   assign col_inc  = {1'b0, col_ff} + (CW+1)'(1);
   assign eol      = col_inc == (CW+1)'(WIDTH);
   assign last_row = row_ff == RW'(HEIGHT - 1);

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      line_next = 1'b0;
      if (req_data.op == OP_PUT) begin
         if (newline || eol) begin
            line_next = 1'b1;
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
      if (line_next) begin
         col_in = '0;
         if (!last_row) begin
            row_in = row_ff + RW'(1);
         end
      end
      if (req_data.op == OP_CLEAR) begin
         col_in = '0;
         row_in = '0;
      end
   end

   assign status.will_scroll = line_next && last_row;
   assign status.is_newline  = newline;
   assign status.sweep_busy  = sweep_on_ff || wr_pend_ff;

   assign pos_cur  = AW'(row_ff) * AW'(WIDTH) + AW'(col_ff);
   assign pos_next = AW'(row_in) * AW'(WIDTH) + AW'(col_in);
   assign idx_wide = 32'(req_data.cell_index);
   assign idx_addr = idx_wide[AW-1:0];

   assign ram_we    = wr_pend_ff || cmd.cell_write;
   assign ram_waddr = wr_pend_ff ? wr_addr_ff : pos_cur;
   assign ram_raddr = sweep_on_ff ? sweep_cnt_ff + AW'(WIDTH) : idx_addr;

   always_comb begin
      if (wr_pend_ff) begin
         ram_wdata = wr_copy_ff ? ram_q : fill_ff;
      end else begin
         ram_wdata = make_cell(bg_ff, fg_ff, req_data.char_code);
      end
   end

   tcw_ram #(
      .DATA_W (16),
      .DEPTH  (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff         <= FG_RESET;
         bg_ff         <= BG_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         sweep_on_ff   <= 1'b1;
         sweep_cnt_ff  <= '0;
         sweep_copy_ff <= 1'b0;
         fill_ff       <= CELL_RESET;
         wr_pend_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_FG: fg_ff <= csr_wdata;
               REG_BG: bg_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.cursor_load) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (cmd.sweep_start) begin
            sweep_on_ff   <= 1'b1;
            sweep_cnt_ff  <= '0;
            sweep_copy_ff <= !cmd.sweep_clear;
            fill_ff       <= cmd.sweep_clear ? make_cell(req_data.clear_bg, fg_ff, CH_SPACE)
                                             : make_cell(bg_ff, fg_ff, CH_SPACE);
         end else if (sweep_on_ff) begin
            sweep_cnt_ff <= sweep_cnt_ff + AW'(1);
            if (sweep_cnt_ff == AW'(CELLS - 1)) begin
               sweep_on_ff <= 1'b0;
            end
         end
         wr_pend_ff <= sweep_on_ff;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= sweep_cnt_ff;
      wr_copy_ff <= sweep_copy_ff && (sweep_cnt_ff < AW'(CELLS - WIDTH));
      if (cmd.read_issue) begin
         in_range_ff <= idx_wide < 32'(CELLS);
      end
      if (cmd.rsp_load_step) begin
         rsp_ff.cursor_pos <= to_pos(pos_next);
         rsp_ff.read_data  <= '0;
      end else if (cmd.rsp_load_read) begin
         rsp_ff.cursor_pos <= to_pos(pos_cur);
         rsp_ff.read_data  <= in_range_ff ? ram_q : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character cell store with cursor, wrap, scroll, clear.
//
//   channel | direction | handshake          | beat
//   req     | in        | req_valid/ready    | req_type: op, char, bg, index
//   rsp     | out       | rsp_valid/ready    | rsp_type: cursor, cell word
//   csr     | in        | csr_we             | index 0 fg, 1 bg; 4-bit data
//
// A put or an unused op is answered from the idle state, a read after a read state (registered store port).
// Scroll and clear walk the store one cell a cycle with the input held off;
// the result beat is issued at the start.
// After reset a clearing pass over the whole store holds req_ready low.
// A waiting result beat holds req_ready low except in the cycle rsp_ready takes it.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
   parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [3:0]       csr_wdata
);
   import tcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_checker #(
   parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
   parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input tcw_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tcw_pkg::rsp_type rsp_data,
   input logic             csr_we,
   input logic [0:0]       csr_index,
   input logic [3:0]       csr_wdata
);
   import tcw_pkg::*;

   localparam int CELLS = WIDTH * HEIGHT;

   `TCW_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped")
   `TCW_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "result beat changed")
   `TCW_ASSERT(a_pos_range, rsp_valid |-> 32'(rsp_data.cursor_pos) < CELLS, "cursor off screen")
   `TCW_ASSERT(a_clear_stall, req_valid && req_ready && req_data.op == OP_CLEAR |=> !req_ready, "clear not stalled")
   `TCW_ASSERT_RST(a_reset_stall, reset |=> !req_ready, "input taken during clearing pass")

endmodule

bind text_console_writer tcw_checker #(
   .WIDTH  (WIDTH),
   .HEIGHT (HEIGHT)
) u_tcw_checker (.*);

>>> tb/text_console_writer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the request, response and register ports of the console writer,
// keeps its own copy of the screen, cursor and colors, works out the reply
// for every accepted request beat and compares each response beat, field by
// field, against the oldest reply still owed.
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
   parameter int WIDTH  = tcw_pkg::WIDTH_DEF,
   parameter int HEIGHT = tcw_pkg::HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  tcw_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  tcw_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [3:0]       csr_wdata,
   output int               mismatch_count,
   output int               owed_count,
   output int               scroll_count
);
   import tcw_pkg::*;

   localparam int CELLS = WIDTH * HEIGHT;

   cell_type   shadow_screen [CELLS];
   int         cur_col;
   int         cur_row;
   logic [3:0] fg_shade;
   logic [3:0] bg_shade;
   rsp_type    owed_replies [$];
   int         scrolls;
   int         errors;

   function automatic void scroll_screen();
      for (int i = 0; i < CELLS - WIDTH; i++)
         shadow_screen[i] = shadow_screen[i + WIDTH];
      for (int i = CELLS - WIDTH; i < CELLS; i++)
         shadow_screen[i] = {bg_shade, fg_shade, CH_SPACE};
      scrolls++;
   endfunction

   function automatic void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row >= HEIGHT) begin
         scroll_screen();
         cur_row = HEIGHT - 1;
      end
   endfunction

   function automatic rsp_type step_console(req_type item);
      rsp_type reply;
      reply.read_data = '0;
      case (item.op)
         OP_PUT: begin
            if (item.char_code == CH_NEWLINE) begin
               line_feed();
            end else begin
               shadow_screen[cur_row * WIDTH + cur_col] = {bg_shade, fg_shade, item.char_code};
               cur_col++;
               if (cur_col >= WIDTH)
                  line_feed();
            end
         end
         OP_CLEAR: begin
            foreach (shadow_screen[i])
               shadow_screen[i] = {item.clear_bg, fg_shade, CH_SPACE};
            cur_col = 0;
            cur_row = 0;
         end
         OP_READ: begin
            if (item.cell_index < CELLS)
               reply.read_data = shadow_screen[item.cell_index];
         end
         default: ;
      endcase
      reply.cursor_pos = 11'(cur_row * WIDTH + cur_col);
      return reply;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (shadow_screen[i])
            shadow_screen[i] = CELL_RESET;
         cur_col = 0;
         cur_row = 0;
         fg_shade = FG_RESET;
         bg_shade = BG_RESET;
         owed_replies.delete();
         scrolls = 0;
         errors = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FG: fg_shade = csr_wdata;
               REG_BG: bg_shade = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            owed_replies.push_back(step_console(req_data));
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               if (errors < 10)
                  $display("%0t: response beat with none owed: cursor_pos %0d read_data %h",
                           $realtime, rsp_data.cursor_pos, rsp_data.read_data);
               errors++;
            end else begin
               want = owed_replies.pop_front();
               if (rsp_data.cursor_pos !== want.cursor_pos
                   || rsp_data.read_data !== want.read_data) begin
                  if (errors < 10)
                     $display("%0t: cursor_pos exp %0d got %0d, read_data exp %h got %h",
                              $realtime, want.cursor_pos, rsp_data.cursor_pos,
                              want.read_data, rsp_data.read_data);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      owed_count <= owed_replies.size();
      scroll_count <= scrolls;
   end

endmodule

>>> tb/text_console_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Drives the console writer with a directed opening (reset screen, byte and
// index extremes, newline, clear, unused op) and then random puts, reads,
// clears and unused ops under six color settings, with sender and receiver
// idling in turn. The checker beside the block supplies the failure count.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int WIDTH         = WIDTH_DEF;
   localparam int HEIGHT        = HEIGHT_DEF;
   localparam int CELLS         = WIDTH * HEIGHT;
   localparam int SWEEP_WAIT    = CELLS + 40;
   localparam int STALL_LIMIT   = 20000;
   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_ITEMS = 320;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [0:0] csr_index = '0;
   logic [3:0] csr_wdata = '0;

   int mismatches;
   int owed;
   int scrolls_seen;
   int send_idle_pct = 30;
   int recv_idle_pct = 73;
   int quiet_cycles = 0;
   int op_tally [4] = '{0, 0, 0, 0};
   int feed_tally = 0;
   int color_writes = 0;

   logic [3:0] fg_table [SEGMENTS] = '{4'd0, 4'd15, 4'd5, 4'd15, 4'd0, 4'd9};
   logic [3:0] bg_table [SEGMENTS] = '{4'd0, 4'd15, 4'd10, 4'd0, 4'd15, 4'd6};

   text_console_writer #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   text_console_writer_checker #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) console_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .owed_count     (owed),
      .scroll_count   (scrolls_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat moved in %0d cycles, %0d replies owed", STALL_LIMIT, owed);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type req_beat(logic [1:0] op, logic [7:0] ch, logic [3:0] bg,
                                        logic [10:0] idx);
      req_type item;
      item.op = op;
      item.char_code = ch;
      item.clear_bg = bg;
      item.cell_index = idx;
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      op_tally[item.op]++;
      if (item.op == OP_PUT && item.char_code == CH_NEWLINE)
         feed_tally++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed != 0)
         @(posedge clock);
   endtask

   task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
      drain_results();
      repeat (SWEEP_WAIT) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_FG;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= REG_BG;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we <= 1'b0;
      color_writes++;
   endtask

   initial begin
      req_type item;
      int      pick;
      int      feed_one_in;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'd0));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'(CELLS - 1)));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'(CELLS)));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'h7FF));
      send_item(req_beat(OP_PUT, 8'h41, 4'h0, 11'd0));
      send_item(req_beat(OP_PUT, 8'h00, 4'h0, 11'd0));
      send_item(req_beat(OP_PUT, 8'hFF, 4'h0, 11'd0));
      send_item(req_beat(OP_PUT, CH_NEWLINE, 4'h0, 11'd0));
      send_item(req_beat(OP_PUT, 8'h80, 4'h0, 11'd0));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'd0));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'd1));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'd2));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'(WIDTH)));
      send_item(req_beat(OP_UNUSED, 8'hFF, 4'hF, 11'h7FF));
      send_item(req_beat(OP_CLEAR, 8'h00, 4'hF, 11'd0));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'd0));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'(CELLS - 1)));
      send_item(req_beat(OP_PUT, 8'h7F, 4'h0, 11'd0));
      send_item(req_beat(OP_CLEAR, 8'h00, 4'h0, 11'd0));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'd0));
      send_item(req_beat(OP_READ, 8'h00, 4'h0, 11'd1023));

      fg_table[SEGMENTS - 1] = 4'($urandom);
      bg_table[SEGMENTS - 1] = 4'($urandom);
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 2) begin
            send_idle_pct = 73;
            recv_idle_pct = 30;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_colors(fg_table[seg], bg_table[seg]);
         // alternate short lines (scroll by newline) with long runs (wrap at line end)
         feed_one_in = (seg % 2 == 0) ? 5 : 150;
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            if ($urandom_range(99) == 0)
               drain_results();
            pick = $urandom_range(99);
            item.op = OP_READ;
            item.char_code = 8'($urandom);
            item.clear_bg = 4'($urandom);
            item.cell_index = 11'($urandom);
            if (pick < 58) begin
               item.op = OP_PUT;
               if ($urandom_range(feed_one_in - 1) == 0)
                  item.char_code = CH_NEWLINE;
            end else if (pick == 58 && $urandom_range(2) == 0) begin
               item.op = OP_CLEAR;
            end else if (pick < 97) begin
               if ($urandom_range(1) == 0)
                  item.cell_index = 11'($urandom_range(CELLS - 1, CELLS - 3 * WIDTH));
            end else begin
               item.op = OP_UNUSED;
            end
            send_item(item);
         end
      end

      drain_results();
      repeat (SWEEP_WAIT) @(posedge clock);
      $display("Run covered %0d puts (%0d line feeds), %0d clears, %0d reads, %0d unused ops",
               op_tally[OP_PUT], feed_tally, op_tally[OP_CLEAR], op_tally[OP_READ],
               op_tally[OP_UNUSED]);
      $display("with %0d screen scrolls over %0d color settings and three idling modes",
               scrolls_seen, color_writes);
      if (mismatches == 0 && owed == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
